@@ hdl/mscr_pkg.sv @@
package mscr_pkg;

    localparam int COUNTER_BITS = 24;
    localparam int FRAC_BITS    = 16;
    localparam int RATIO_BITS   = FRAC_BITS + 1;
    localparam int ITER_BITS    = $clog2(FRAC_BITS + 1);
    localparam int THRESH_BITS  = 16;
    localparam int FIELD_BITS   = 16;

    localparam logic [RATIO_BITS-1:0] RATIO_ONE = RATIO_BITS'(1) << FRAC_BITS;
    localparam logic [COUNTER_BITS-1:0] CNT_MAX = '1;

    typedef struct packed {
        logic                  voxel_bit;
        logic                  mask_bit;
        logic [FIELD_BITS-1:0] field_value;
        logic                  slice_end;
    } t_in_item;

    typedef struct packed {
        logic [RATIO_BITS-1:0] contact_ratio;
        logic                  empty_slice;
    } t_out_item;

    typedef enum logic [1:0] {
        ST_ACCUM,
        ST_DIVIDE,
        ST_OUTPUT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic count;     // a voxel transfer happens this cycle
        logic load;      // that voxel closes the slice: snapshot and clear
        logic step;      // advance the divider by one quotient bit
        logic capture;   // move the finished result into the output register
    } t_dp_cmd;

    typedef struct packed {
        logic div_done;
    } t_dp_status;

endpackage

@@ hdl/mscr_datapath.sv @@
module mscr_datapath
    import mscr_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_dp_cmd                i_cmd,
    input  t_in_item               i_item,
    input  logic [THRESH_BITS-1:0] i_threshold,
    output t_dp_status             o_status,
    output t_out_item              o_result
);

    logic [COUNTER_BITS-1:0] r_near, n_near;
    logic [COUNTER_BITS-1:0] r_mat, n_mat;
    logic [COUNTER_BITS-1:0] r_div;
    logic [COUNTER_BITS-1:0] r_rem, n_rem;
    logic [FRAC_BITS-1:0]    r_quot;
    logic [ITER_BITS-1:0]    r_iter;
    logic                    r_empty;
    logic                    r_equal;
    t_out_item               r_result, n_result;

    logic                    is_near;
    logic [COUNTER_BITS:0]   shifted;
    logic                    fits;

    assign is_near = i_item.mask_bit && (i_item.field_value != '0)
                     && (i_item.field_value < i_threshold);

    always_comb begin
        n_near = r_near;
        n_mat  = r_mat;
        if (is_near) begin
            if (r_near != CNT_MAX) n_near = r_near + 1'b1;
            if (i_item.voxel_bit && (r_mat != CNT_MAX)) n_mat = r_mat + 1'b1;
        end
    end

    // Restoring division of material * 2^16 by near. The partial remainder
    // stays at or below the divisor, so one extra bit covers the shift.
    assign shifted = {r_rem, 1'b0};
    assign fits    = shifted >= {1'b0, r_div};
    assign n_rem   = fits ? COUNTER_BITS'(shifted - {1'b0, r_div})
                          : shifted[COUNTER_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_near <= '0;
            r_mat  <= '0;
            r_iter <= '0;
        end else begin
            if (i_cmd.count) begin
                if (i_cmd.load) begin
                    r_near <= '0;
                    r_mat  <= '0;
                    r_iter <= ITER_BITS'(FRAC_BITS);
                end else begin
                    r_near <= n_near;
                    r_mat  <= n_mat;
                end
            end else if (i_cmd.step && (r_iter != '0)) begin
                r_iter <= r_iter - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.count && i_cmd.load) begin
            r_div   <= n_near;
            r_rem   <= n_mat;
            r_quot  <= '0;
            r_empty <= (n_near == '0);
            r_equal <= (n_mat == n_near);
        end else if (i_cmd.step && (r_iter != '0)) begin
            r_rem  <= n_rem;
            r_quot <= {r_quot[FRAC_BITS-2:0], fits};
        end
    end

    assign o_status.div_done = (r_iter == '0);

    always_comb begin
        n_result.empty_slice = r_empty;
        if (r_empty || r_equal) begin
            n_result.contact_ratio = '0;
        end else begin
            n_result.contact_ratio = RATIO_ONE - {1'b0, r_quot};
        end
    end

    // The output register frees the divider, so the next slice can accumulate
    // while a result waits.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_result <= n_result;
        end
    end

    assign o_result = r_result;

endmodule

@@ hdl/mscr_ctrl.sv @@
module mscr_ctrl
    import mscr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_slice_end,
    input  logic       i_out_stall,
    input  t_dp_status i_status,
    output logic       o_in_stall,
    output logic       o_out_valid,
    output t_dp_cmd    o_cmd
);

    t_state r_state, n_state;
    logic   r_out_full, n_out_full;
    logic   out_free;

    // The output register can take a new result when empty or being drained.
    assign out_free    = !r_out_full || !i_out_stall;
    assign o_out_valid = r_out_full;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_ACCUM: begin
                if (i_in_valid && i_slice_end) n_state = ST_DIVIDE;
            end
            ST_DIVIDE: begin
                if (i_status.div_done) n_state = ST_OUTPUT;
            end
            ST_OUTPUT: begin
                if (out_free) n_state = ST_ACCUM;
            end
            default: n_state = ST_ACCUM;
        endcase
    end

    always_comb begin
        o_in_stall  = 1'b1;
        o_cmd       = '0;
        unique case (r_state)
            ST_ACCUM: begin
                o_in_stall = 1'b0;
                o_cmd.count = i_in_valid;
                o_cmd.load  = i_in_valid && i_slice_end;
            end
            ST_DIVIDE: begin
                o_cmd.step = 1'b1;
            end
            ST_OUTPUT: begin
                o_cmd.capture = out_free;
            end
            default: o_in_stall = 1'b1;
        endcase
    end

    assign n_out_full = o_cmd.capture || (r_out_full && i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_ACCUM;
            r_out_full <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_out_full <= n_out_full;
        end
    end

endmodule

@@ hdl/masked_slice_contact_ratio_unit.sv @@
// Channel   Direction  Handshake                Payload
// input     in         i_in_valid / o_in_stall   i_in_data  (t_in_item)
// output    out        o_out_valid / i_out_stall o_out_data (t_out_item)
// config    in         i_cfg_valid / o_cfg_ready i_cfg_data (near_threshold)
//
// Voxels are taken one per cycle while a slice accumulates.
// A voxel with slice_end starts a 16-step bit-serial divider; the input stalls from that transfer
// through the division, the done check and the move into the output register.
// The result then waits in the output register while the next slice accumulates; a hand-over
// waits while that register is full and the output is stalled.
// Synchronous active-low reset clears the counters and the threshold to zero.
module masked_slice_contact_ratio_unit
    import mscr_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  t_in_item               i_in_data,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output t_out_item              o_out_data,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [THRESH_BITS-1:0] i_cfg_data
);

    logic [THRESH_BITS-1:0] r_threshold;
    t_dp_cmd                cmd;
    t_dp_status             status;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_threshold <= i_cfg_data;
        end
    end

    mscr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_slice_end (i_in_data.slice_end),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    mscr_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_item      (i_in_data),
        .i_threshold (r_threshold),
        .o_status    (status),
        .o_result    (o_out_data)
    );

`ifndef NO_ASSERTIONS
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result changed or dropped");

    a_slice_end_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_in_data.slice_end) |=> o_in_stall)
        else $error("slice end did not start the divider");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.empty_slice) |-> (o_out_data.contact_ratio == '0))
        else $error("empty slice with nonzero ratio");

    a_ratio_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.contact_ratio <= RATIO_ONE))
        else $error("ratio above one");
`endif

endmodule
